/* sv/osfc_pkg.sv */
// Package for the observer/state-feedback controller.
// Holds the microcode types, the control ROM and the fixed-point constants.
// No dependencies.
`default_nettype none

package osfc_pkg;

   // Sequencer geometry
   localparam int PC_W     = 6;
   localparam int PROG_LEN = 39;

   localparam logic [PC_W-1:0] STEP_WAIT = 6'd0;
   localparam logic [PC_W-1:0] STEP_HOLD = 6'd37;

   // Datapath widths
   localparam int OPD_W  = 33;
   localparam int GAIN_W = 22;
   localparam int PROD_W = OPD_W + GAIN_W;
   localparam int ACC_W  = 64;
   localparam int RND_W  = ACC_W - 16;

   // Fixed-point constants, Q16.16
   localparam logic signed [32:0] PI_Q     = 33'sd205887;
   localparam logic signed [32:0] TWO_PI_Q = 33'sd411775;
   localparam logic signed [19:0] DRIVE_LIMIT = 20'sd327680;
   localparam logic signed [ACC_W-1:0] RND_HALF = 64'sd32768;
   localparam logic signed [RND_W-1:0] S32_MAX = 48'sd2147483647;
   localparam logic signed [RND_W-1:0] S32_MIN = -48'sd2147483648;
   localparam logic signed [RND_W-1:0] DRV_MAX = 48'sd327680;
   localparam logic signed [RND_W-1:0] DRV_MIN = -48'sd327680;

   // Multiplier operand select
   typedef enum logic [3:0] {
      OPA_PRED0, OPA_PRED1, OPA_PRED2, OPA_PRED3,
      OPA_ARM, OPA_PEND,
      OPA_EST0, OPA_EST1, OPA_EST2, OPA_EST3,
      OPA_REF, OPA_DRIVE
   } opa_type;

   // Accumulator operation
   typedef enum logic [1:0] {
      ACC_HOLD, ACC_LOAD, ACC_ADD, ACC_SUB
   } accop_type;

   // Write-back target of the rounded accumulator
   typedef enum logic [3:0] {
      DST_NONE,
      DST_EST0, DST_EST1, DST_EST2, DST_EST3,
      DST_DRIVE,
      DST_PRED0, DST_PRED1, DST_PRED2, DST_PRED3
   } dest_type;

   // Jump condition
   typedef enum logic [1:0] {
      COND_NEVER, COND_ALWAYS, COND_NO_INPUT, COND_OUT_BUSY
   } cond_type;

   // One control word
   typedef struct packed {
      opa_type                   opa;
      logic signed [GAIN_W-1:0]  gain;
      accop_type                 accop;
      dest_type                  dest;
      cond_type                  cond;
      logic [PC_W-1:0]           target;
      logic                      emit;
   } cw_type;

   // Multiply-accumulate step
   function automatic cw_type osfc_mac(opa_type a, logic signed [GAIN_W-1:0] g,
                                       accop_type o);
      cw_type cw;
      cw = '{opa: a, gain: g, accop: o, dest: DST_NONE, cond: COND_NEVER,
             target: STEP_WAIT, emit: 1'b0};
      return cw;
   endfunction

   // Write-back step
   function automatic cw_type osfc_wr(dest_type d);
      cw_type cw;
      cw = '{opa: OPA_ARM, gain: '0, accop: ACC_HOLD, dest: d, cond: COND_NEVER,
             target: STEP_WAIT, emit: 1'b0};
      return cw;
   endfunction

   // Flow-control step
   function automatic cw_type osfc_jmp(cond_type c, logic [PC_W-1:0] t, logic e);
      cw_type cw;
      cw = '{opa: OPA_ARM, gain: '0, accop: ACC_HOLD, dest: DST_NONE, cond: c,
             target: t, emit: e};
      return cw;
   endfunction

   // Microprogram ROM
   function automatic cw_type osfc_rom(logic [PC_W-1:0] step);
      cw_type cw;
      unique case (step)
         // wait for an input transfer
         6'd0:  cw = osfc_jmp(COND_NO_INPUT, STEP_WAIT, 1'b0);
         // estimate, arm angle
         6'd1:  cw = osfc_mac(OPA_PRED0, 22'sd65536, ACC_LOAD);
         6'd2:  cw = osfc_mac(OPA_ARM, 22'sd65162, ACC_ADD);
         6'd3:  cw = osfc_wr(DST_EST0);
         // estimate, pendulum angle
         6'd4:  cw = osfc_mac(OPA_PRED1, 22'sd65536, ACC_LOAD);
         6'd5:  cw = osfc_mac(OPA_PEND, 22'sd65162, ACC_ADD);
         6'd6:  cw = osfc_wr(DST_EST1);
         // estimate, arm rate
         6'd7:  cw = osfc_mac(OPA_PRED2, 22'sd65536, ACC_LOAD);
         6'd8:  cw = osfc_mac(OPA_ARM, 22'sd151, ACC_ADD);
         6'd9:  cw = osfc_mac(OPA_PEND, -22'sd465, ACC_ADD);
         6'd10: cw = osfc_wr(DST_EST2);
         // estimate, pendulum rate
         6'd11: cw = osfc_mac(OPA_PRED3, 22'sd65536, ACC_LOAD);
         6'd12: cw = osfc_mac(OPA_ARM, -22'sd505, ACC_ADD);
         6'd13: cw = osfc_mac(OPA_PEND, 22'sd19582, ACC_ADD);
         6'd14: cw = osfc_wr(DST_EST3);
         // drive
         6'd15: cw = osfc_mac(OPA_REF, -22'sd338742, ACC_LOAD);
         6'd16: cw = osfc_mac(OPA_EST0, -22'sd338742, ACC_SUB);
         6'd17: cw = osfc_mac(OPA_EST1, 22'sd1819718, ACC_SUB);
         6'd18: cw = osfc_mac(OPA_EST2, -22'sd178415, ACC_SUB);
         6'd19: cw = osfc_mac(OPA_EST3, 22'sd208319, ACC_SUB);
         6'd20: cw = osfc_wr(DST_DRIVE);
         // prediction 0 and 1
         6'd21: cw = osfc_mac(OPA_EST0, 22'sd374, ACC_LOAD);
         6'd22: cw = osfc_wr(DST_PRED0);
         6'd23: cw = osfc_mac(OPA_EST1, 22'sd374, ACC_LOAD);
         6'd24: cw = osfc_wr(DST_PRED1);
         // prediction 2
         6'd25: cw = osfc_mac(OPA_DRIVE, 22'sd6639, ACC_LOAD);
         6'd26: cw = osfc_mac(OPA_EST0, -22'sd151, ACC_ADD);
         6'd27: cw = osfc_mac(OPA_EST1, 22'sd6940, ACC_ADD);
         6'd28: cw = osfc_mac(OPA_EST2, 22'sd61887, ACC_ADD);
         6'd29: cw = osfc_mac(OPA_EST3, -22'sd72, ACC_ADD);
         6'd30: cw = osfc_wr(DST_PRED2);
         // prediction 3
         6'd31: cw = osfc_mac(OPA_DRIVE, 22'sd6390, ACC_LOAD);
         6'd32: cw = osfc_mac(OPA_EST0, 22'sd505, ACC_ADD);
         6'd33: cw = osfc_mac(OPA_EST1, -22'sd9778, ACC_ADD);
         6'd34: cw = osfc_mac(OPA_EST2, -22'sd3506, ACC_ADD);
         6'd35: cw = osfc_mac(OPA_EST3, 22'sd65405, ACC_ADD);
         6'd36: cw = osfc_wr(DST_PRED3);
         // hold until the output register is free, then load it
         6'd37: cw = osfc_jmp(COND_OUT_BUSY, STEP_HOLD, 1'b0);
         6'd38: cw = osfc_jmp(COND_ALWAYS, STEP_WAIT, 1'b1);
         default: cw = osfc_jmp(COND_ALWAYS, STEP_WAIT, 1'b0);
      endcase
      return cw;
   endfunction

endpackage

`default_nettype wire

/* sv/osfc_if.sv */
// Channel interfaces of the observer/state-feedback controller:
// input samples, results and the reference-angle register write.
// No dependencies.
`default_nettype none

interface osfc_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] arm_angle;
   logic signed [31:0] pendulum_angle;
   modport source (output valid, arm_angle, pendulum_angle, input ready);
   modport sink   (input valid, arm_angle, pendulum_angle, output ready);
endinterface

interface osfc_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [19:0] drive_value;
   logic signed [31:0] est_arm_angle;
   logic signed [31:0] est_pendulum_angle;
   logic signed [31:0] est_arm_rate;
   logic signed [31:0] est_pendulum_rate;
   modport source (output valid, drive_value, est_arm_angle, est_pendulum_angle,
                   est_arm_rate, est_pendulum_rate, input ready);
   modport sink   (input valid, drive_value, est_arm_angle, est_pendulum_angle,
                   est_arm_rate, est_pendulum_rate, output ready);
endinterface

interface osfc_csr_if;
   logic               valid;
   logic               ready;
   logic signed [19:0] reference_angle;
   modport source (output valid, reference_angle, input ready);
   modport sink   (input valid, reference_angle, output ready);
endinterface

`default_nettype wire

/* sv/observer_state_feedback_controller.sv */
// Observer/state-feedback controller top level: microcoded sequencer driving
// one shared multiplier and a 64-bit accumulator.
// Depends on osfc_pkg and the interfaces in osfc_if.sv.
//
//   channel | direction | payload                                | transfer
//   req     | in        | arm_angle, pendulum_angle              | valid & ready
//   rsp     | out       | drive_value, est_* (four estimates)    | valid & ready
//   csr     | in        | reference_angle                        | valid & ready
//
// One sample runs the 39-step control program through the single multiplier;
// a new input is taken only once the program is back at its wait step.
// Reset (synchronous) clears prediction, reference and the sequencer.
// A result waiting in the output register does not block the next input;
// the program stalls at its hold step only if that result is still untaken.
// csr is always ready; write it only while the block is idle.
`default_nettype none

module observer_state_feedback_controller (
   input  wire logic  clock,
   input  wire logic  reset,
   osfc_req_if.sink   req,
   osfc_rsp_if.source rsp,
   osfc_csr_if.sink   csr
);
   import osfc_pkg::*;

   // Sequencer
   logic [PC_W-1:0] pc_ff, pc_in;
   cw_type          cw;
   logic            jump;

   // Operand and state registers
   logic signed [OPD_W-1:0] arm_ff, arm_in;
   logic signed [31:0]      pend_ff;
   logic signed [31:0]      est_ff [4];
   logic signed [31:0]      pred_ff [4];
   logic signed [19:0]      drive_ff;
   logic signed [19:0]      ref_ff;

   // MAC pipeline
   logic signed [OPD_W-1:0]  opd;
   logic signed [PROD_W-1:0] prod_ff;
   accop_type                accop1_ff;
   dest_type                 dest1_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [ACC_W-1:0]  rnd;
   logic signed [RND_W-1:0]  quo;
   logic signed [31:0]       sat32;
   logic signed [19:0]       satdrv;

   // Output register
   logic               rsp_valid_ff;
   logic signed [19:0] out_drive_ff;
   logic signed [31:0] out_est_ff [4];

   // Control word fetch and next step
   always_comb begin
      cw   = osfc_rom(pc_ff);
      jump = 1'b0;
      unique case (cw.cond)
         COND_NEVER:    jump = 1'b0;
         COND_ALWAYS:   jump = 1'b1;
         COND_NO_INPUT: jump = !req.valid;
         COND_OUT_BUSY: jump = rsp_valid_ff && !rsp.ready;
         default:       jump = 1'b0;
      endcase
      pc_in = jump ? cw.target : pc_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= STEP_WAIT;
      end else begin
         pc_ff <= pc_in;
      end
   end

   assign req.ready = (cw.cond == COND_NO_INPUT);
   assign csr.ready = 1'b1;

   // Encoder wrap correction on the arm angle
   always_comb begin
      arm_in = OPD_W'(req.arm_angle);
      if (arm_in < -PI_Q) begin
         arm_in = arm_in + TWO_PI_Q;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         arm_ff  <= arm_in;
         pend_ff <= req.pendulum_angle;
      end
   end

   // Reference register
   always_ff @(posedge clock) begin
      if (reset) begin
         ref_ff <= '0;
      end else if (csr.valid && csr.ready) begin
         ref_ff <= csr.reference_angle;
      end
   end

   // Operand select
   always_comb begin
      unique case (cw.opa)
         OPA_PRED0: opd = OPD_W'(pred_ff[0]);
         OPA_PRED1: opd = OPD_W'(pred_ff[1]);
         OPA_PRED2: opd = OPD_W'(pred_ff[2]);
         OPA_PRED3: opd = OPD_W'(pred_ff[3]);
         OPA_ARM:   opd = arm_ff;
         OPA_PEND:  opd = OPD_W'(pend_ff);
         OPA_EST0:  opd = OPD_W'(est_ff[0]);
         OPA_EST1:  opd = OPD_W'(est_ff[1]);
         OPA_EST2:  opd = OPD_W'(est_ff[2]);
         OPA_EST3:  opd = OPD_W'(est_ff[3]);
         OPA_REF:   opd = OPD_W'(ref_ff);
         OPA_DRIVE: opd = OPD_W'(drive_ff);
         default:   opd = '0;
      endcase
   end

   // Stage 1: product register, control carried alongside
   always_ff @(posedge clock) begin
      prod_ff <= opd * cw.gain;
      if (reset) begin
         accop1_ff <= ACC_HOLD;
         dest1_ff  <= DST_NONE;
      end else begin
         accop1_ff <= cw.accop;
         dest1_ff  <= cw.dest;
      end
   end

   // Stage 2: accumulate
   always_ff @(posedge clock) begin
      case (accop1_ff)
         ACC_LOAD: acc_ff <= ACC_W'(prod_ff);
         ACC_ADD:  acc_ff <= acc_ff + ACC_W'(prod_ff);
         ACC_SUB:  acc_ff <= acc_ff - ACC_W'(prod_ff);
         default:  acc_ff <= acc_ff;
      endcase
   end

   // Round half up to Q16.16, then saturate
   always_comb begin
      rnd = acc_ff + RND_HALF;
      quo = rnd[ACC_W-1:16];
      if (quo > S32_MAX) begin
         sat32 = S32_MAX[31:0];
      end else if (quo < S32_MIN) begin
         sat32 = S32_MIN[31:0];
      end else begin
         sat32 = quo[31:0];
      end
      if (quo > DRV_MAX) begin
         satdrv = DRIVE_LIMIT;
      end else if (quo < DRV_MIN) begin
         satdrv = -DRIVE_LIMIT;
      end else begin
         satdrv = quo[19:0];
      end
   end

   // Write-back
   always_ff @(posedge clock) begin
      if (reset) begin
         pred_ff[0] <= '0;
         pred_ff[1] <= '0;
         pred_ff[2] <= '0;
         pred_ff[3] <= '0;
         drive_ff   <= '0;
      end else begin
         case (dest1_ff)
            DST_EST0:  est_ff[0]  <= sat32;
            DST_EST1:  est_ff[1]  <= sat32;
            DST_EST2:  est_ff[2]  <= sat32;
            DST_EST3:  est_ff[3]  <= sat32;
            DST_DRIVE: drive_ff   <= satdrv;
            DST_PRED0: pred_ff[0] <= sat32;
            DST_PRED1: pred_ff[1] <= sat32;
            DST_PRED2: pred_ff[2] <= sat32;
            DST_PRED3: pred_ff[3] <= sat32;
            default: ;
         endcase
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cw.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cw.emit) begin
         out_drive_ff  <= -drive_ff;
         out_est_ff[0] <= est_ff[0];
         out_est_ff[1] <= est_ff[1];
         out_est_ff[2] <= est_ff[2];
         out_est_ff[3] <= est_ff[3];
      end
   end

   assign rsp.valid              = rsp_valid_ff;
   assign rsp.drive_value        = out_drive_ff;
   assign rsp.est_arm_angle      = out_est_ff[0];
   assign rsp.est_pendulum_angle = out_est_ff[1];
   assign rsp.est_arm_rate       = out_est_ff[2];
   assign rsp.est_pendulum_rate  = out_est_ff[3];

   // Checks
   a_pc_range: assert property (@(posedge clock) disable iff (reset)
      pc_ff < PC_W'(PROG_LEN))
      else $error("sequencer step out of program");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cw.emit |-> !rsp_valid_ff)
      else $error("result loaded over an untaken one");

   a_emit_valid: assert property (@(posedge clock) disable iff (reset)
      cw.emit |=> rsp_valid_ff)
      else $error("loaded result not presented");

   a_drive_range: assert property (@(posedge clock) disable iff (reset)
      drive_ff <= DRIVE_LIMIT && drive_ff >= -DRIVE_LIMIT)
      else $error("drive outside saturation limits");

   a_in_idle: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |-> (accop1_ff == ACC_HOLD && dest1_ff == DST_NONE))
      else $error("input taken while datapath busy");

endmodule

`default_nettype wire

/* bench/tb.sv */
// Testbench for observer_state_feedback_controller: drives angle samples and
// reference writes, predicts each drive/estimate result and compares on transfer.
// Depends on osfc_pkg, the channel interfaces in osfc_if.sv and the top level.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   // Q16.16 constants of the controller
   localparam longint PI_Q        = 205887;
   localparam longint TWO_PI_Q    = 411775;
   localparam longint DRIVE_LIMIT = 327680;
   localparam longint S32_HI      = 64'sd2147483647;
   localparam longint S32_LO      = -64'sd2147483648;

   localparam int QUIET_LIMIT = 3000;   // cycles without any transfer
   localparam int HOLD_CYCLES = 400;    // long receiver hold-off
   localparam int TAIL_CYCLES = 60;     // settle time after the last result

   typedef struct packed {
      logic signed [31:0] arm;
      logic signed [31:0] pend;
   } angle_pair_type;

   typedef struct packed {
      logic signed [19:0] drive;
      logic signed [31:0] est_arm, est_pend, est_arm_rate, est_pend_rate;
   } control_out_type;

   logic clock;
   logic reset;

   osfc_req_if req_ch();
   osfc_rsp_if rsp_ch();
   osfc_csr_if csr_ch();

   observer_state_feedback_controller uut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch),
      .csr   (csr_ch)
   );

   always #2 clock = ~clock;

   // Predictor state: stored prediction and reference setting
   longint predicted_state[4];
   longint reference_q;

   angle_pair_type  pending[$];
   control_out_type results_due[$];

   int items_queued;
   int samples_taken;
   int results_seen;
   int csr_writes;
   int fault_count;
   int quiet_cycles;
   logic req_taken;

   // Sender burst/gap bookkeeping
   int burst_left;
   int gap_left;

   // Receiver stall pattern and long hold-off handshake
   int hold_asked;
   int hold_served;
   int hold_left;
   int sink_tick;
   int sink_style;

   function automatic longint round_q16(longint acc);
      return (acc + 32768) >>> 16;
   endfunction

   function automatic longint clamp(longint v, longint lo, longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   // One control step: estimate, saturated drive, next prediction
   function automatic control_out_type step_controller(logic signed [31:0] arm_in,
                                                       logic signed [31:0] pend_in);
      longint arm, pend, drive, neg_drive;
      longint est[4];
      control_out_type res;
      arm  = arm_in;
      pend = pend_in;
      // encoder wrap: strictly below -pi only
      if (arm < -PI_Q) arm = arm + TWO_PI_Q;

      est[0] = clamp(round_q16(predicted_state[0] * 65536 + 65162 * arm), S32_LO, S32_HI);
      est[1] = clamp(round_q16(predicted_state[1] * 65536 + 65162 * pend), S32_LO, S32_HI);
      est[2] = clamp(round_q16(predicted_state[2] * 65536 + 151 * arm - 465 * pend),
                     S32_LO, S32_HI);
      est[3] = clamp(round_q16(predicted_state[3] * 65536 - 505 * arm + 19582 * pend),
                     S32_LO, S32_HI);

      drive = clamp(round_q16(-338742 * reference_q + 338742 * est[0] - 1819718 * est[1]
                              + 178415 * est[2] - 208319 * est[3]),
                    -DRIVE_LIMIT, DRIVE_LIMIT);

      predicted_state[0] = clamp(round_q16(374 * est[0]), S32_LO, S32_HI);
      predicted_state[1] = clamp(round_q16(374 * est[1]), S32_LO, S32_HI);
      predicted_state[2] = clamp(round_q16(6639 * drive - 151 * est[0] + 6940 * est[1]
                                           + 61887 * est[2] - 72 * est[3]),
                                 S32_LO, S32_HI);
      predicted_state[3] = clamp(round_q16(6390 * drive + 505 * est[0] - 9778 * est[1]
                                           - 3506 * est[2] + 65405 * est[3]),
                                 S32_LO, S32_HI);

      neg_drive         = -drive;
      res.drive         = neg_drive[19:0];
      res.est_arm       = est[0][31:0];
      res.est_pend      = est[1][31:0];
      res.est_arm_rate  = est[2][31:0];
      res.est_pend_rate = est[3][31:0];
      return res;
   endfunction

   function automatic void check_field(string field, longint want, longint got);
      if (want != got) begin
         fault_count++;
         $display("%0t ns: %s expected %0d, actual %0d", $time, field, want, got);
      end
   endfunction

   function automatic logic signed [31:0] corner_angle();
      case ($urandom_range(0, 5))
         0: return 32'sh80000000;
         1: return 32'sh7FFFFFFF;
         2: return 32'sd0;
         3: return -32'sd1;
         4: return -32'sd205888;
         default: return -32'sd205887;
      endcase
   endfunction

   task automatic queue_sample(input logic signed [31:0] arm, input logic signed [31:0] pend);
      angle_pair_type s;
      s.arm  = arm;
      s.pend = pend;
      pending.push_back(s);
      items_queued++;
   endtask

   // Mostly plausible closed-loop angles, some at the wrap edge, some noise
   task automatic queue_random();
      int pick;
      logic signed [31:0] arm, pend;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         arm  = int'($urandom_range(0, 824000)) - 412000;
         pend = int'($urandom_range(0, 120000)) - 60000;
      end else if (pick < 70) begin
         arm  = -32'sd205887 + int'($urandom_range(0, 6)) - 3;
         pend = int'($urandom_range(0, 4000)) - 2000;
      end else if (pick < 88) begin
         arm  = $urandom;
         pend = $urandom;
      end else begin
         arm  = corner_angle();
         pend = corner_angle();
      end
      queue_sample(arm, pend);
   endtask

   // Sender side idles until every queued sample has its result back
   task automatic wait_all_results();
      while (results_seen < items_queued) @(negedge clock);
   endtask

   task automatic write_reference(input logic signed [19:0] value);
      int want;
      want = csr_writes + 1;
      @(negedge clock);
      csr_ch.valid           <= 1'b1;
      csr_ch.reference_angle <= value;
      @(negedge clock);
      while (csr_writes != want) @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   // Sample driver: bursts of random length with random gaps
   always @(negedge clock) begin : drive_samples
      angle_pair_type next_sample;
      int pick;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_taken) begin
         if (gap_left > 0) begin
            gap_left--;
            req_ch.valid <= 1'b0;
         end else if (pending.size() != 0) begin
            next_sample = pending.pop_front();
            req_ch.valid          <= 1'b1;
            req_ch.arm_angle      <= next_sample.arm;
            req_ch.pendulum_angle <= next_sample.pend;
            if (burst_left > 1) begin
               burst_left--;
            end else begin
               pick = $urandom_range(0, 99);
               burst_left = (pick < 20) ? 40 : $urandom_range(1, 12);
               if (pick < 30)
                  gap_left = 0;
               else if (pick < 70)
                  gap_left = $urandom_range(1, 8);
               else
                  gap_left = $urandom_range(9, 60);
            end
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // Result receiver: stall pattern re-picked at random from time to time, plus long hold-offs
   always @(negedge clock) begin : take_results
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_asked != hold_served) begin
         hold_served = hold_asked;
         hold_left   = HOLD_CYCLES;
         rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ch.ready <= 1'b0;
      end else begin
         sink_tick++;
         if (sink_tick % 256 == 0) sink_style = $urandom_range(0, 3);
         case (sink_style)
            0: rsp_ch.ready <= 1'b1;
            1: rsp_ch.ready <= (sink_tick % 7) < 4;
            2: rsp_ch.ready <= $urandom_range(0, 3) != 0;
            default: rsp_ch.ready <= $urandom_range(0, 4) == 0;
         endcase
      end
   end

   // Transfer monitor: prediction on input, comparison on output
   always @(posedge clock) begin : watch_transfers
      control_out_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_ch.valid && req_ch.ready;
         if (csr_ch.valid && csr_ch.ready) begin
            reference_q = csr_ch.reference_angle;
            csr_writes++;
         end
         if (req_ch.valid && req_ch.ready) begin
            results_due.push_back(step_controller(req_ch.arm_angle, req_ch.pendulum_angle));
            samples_taken++;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            results_seen++;
            if (results_due.size() == 0) begin
               fault_count++;
               $display("%0t ns: result with nothing expected, expected none, actual drive %0d",
                        $time, rsp_ch.drive_value);
            end else begin
               want = results_due.pop_front();
               check_field("drive_value", want.drive, rsp_ch.drive_value);
               check_field("est_arm_angle", want.est_arm, rsp_ch.est_arm_angle);
               check_field("est_pendulum_angle", want.est_pend, rsp_ch.est_pendulum_angle);
               check_field("est_arm_rate", want.est_arm_rate, rsp_ch.est_arm_rate);
               check_field("est_pendulum_rate", want.est_pend_rate, rsp_ch.est_pendulum_rate);
            end
         end
      end
   end

   // Watchdog on cycles with no transfer on any channel
   always @(posedge clock) begin : watchdog
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
          || (csr_ch.valid && csr_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles < QUIET_LIMIT) begin
         quiet_cycles <= quiet_cycles + 1;
      end else begin
         $display("timeout: no transfer for %0d cycles, %0d results outstanding",
                  QUIET_LIMIT, items_queued - results_seen);
         $display("observer_state_feedback_controller: mismatch");
         $finish;
      end
   end

   // Stimulus sequence
   initial begin : run_stimulus
      int k;
      logic signed [19:0] mid_ref;

      clock = 1'b0;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.arm_angle = '0;
      req_ch.pendulum_angle = '0;
      rsp_ch.ready = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.reference_angle = '0;
      for (k = 0; k < 4; k++) predicted_state[k] = 0;
      reference_q   = 0;
      items_queued  = 0;
      samples_taken = 0;
      results_seen  = 0;
      csr_writes    = 0;
      fault_count   = 0;
      quiet_cycles  = 0;
      burst_left    = 1;
      gap_left      = 0;
      hold_asked    = 0;
      hold_served   = 0;
      hold_left     = 0;
      sink_tick     = 0;
      sink_style    = 0;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: field extremes, wrap boundary, saturation build-up (reference 0)
      queue_sample(32'sd0, 32'sd0);
      queue_sample(32'sh7FFFFFFF, 32'sd0);
      queue_sample(32'sh80000000, 32'sd0);
      queue_sample(-32'sd205887, 32'sd0);          // exactly -pi, no wrap
      queue_sample(-32'sd205888, 32'sd0);          // just below -pi, wraps
      queue_sample(32'sd205887, 32'sd0);
      queue_sample(-32'sd205887, -32'sd205888);
      for (k = 0; k < 4; k++) queue_sample(32'sd0, 32'sh7FFFFFFF);
      for (k = 0; k < 4; k++) queue_sample(32'sd0, 32'sh80000000);
      queue_sample(-32'sd1, -32'sd1);
      queue_sample(32'sd1, 32'sd1);
      for (k = 0; k < 2; k++) queue_sample(32'sh7FFFFFFF, 32'sh7FFFFFFF);
      for (k = 0; k < 2; k++) queue_sample(32'sh80000000, 32'sh80000000);
      queue_sample(32'sd411775, -32'sd411775);
      queue_sample(-32'sd411776, 32'sd100);
      wait_all_results();

      // Top of the stated reference range
      write_reference(20'sd411775);
      for (k = 0; k < 150; k++) queue_random();
      wait_all_results();

      // Bottom of the range, with the receiver held off while samples keep coming
      write_reference(-20'sd411775);
      for (k = 0; k < 150; k++) queue_random();
      @(negedge clock);
      hold_asked = hold_asked + 1;
      wait_all_results();

      // Beyond the stated range; sender pauses midway until the block drains
      write_reference(20'sh7FFFF);
      for (k = 0; k < 50; k++) queue_random();
      wait_all_results();
      for (k = 0; k < 50; k++) queue_random();
      wait_all_results();

      write_reference(20'sh80000);
      for (k = 0; k < 100; k++) queue_random();
      wait_all_results();

      // Random in-range reference, second long hold-off
      mid_ref = 20'(int'($urandom_range(0, 823550)) - 411775);
      write_reference(mid_ref);
      for (k = 0; k < 130; k++) queue_random();
      @(negedge clock);
      hold_asked = hold_asked + 1;
      wait_all_results();

      repeat (TAIL_CYCLES) @(posedge clock);
      if (results_due.size() != 0) begin
         fault_count++;
         $display("%0t ns: results left over, expected 0, actual %0d",
                  $time, results_due.size());
      end

      $display("run covered %0d samples and %0d results over %0d reference settings,",
               samples_taken, results_seen, csr_writes + 1);
      $display("including wrap edge, estimate/drive saturation and long output stalls");
      if (fault_count == 0)
         $display("observer_state_feedback_controller: match");
      else
         $display("observer_state_feedback_controller: mismatch");
      $finish;
   end

endmodule

/* files.f */
sv/osfc_pkg.sv
sv/osfc_if.sv
sv/observer_state_feedback_controller.sv
bench/tb.sv
